// File: design/dbsg_pkg.sv
// Shared types and constants of the De Bruijn symbol generator.
// No dependencies; imported by every module of the block.
package dbsg_pkg;

	localparam int MAX_NODES  = 1024;
	localparam int MAX_BASE   = 16;
	localparam int NODE_W     = 10;
	localparam int NCNT_W     = 11;
	localparam int SYM_W      = 4;
	localparam int BASE_W     = 5;
	localparam int WIN_W      = 4;
	localparam int CNT_W      = 15;
	localparam int PROD_W     = 14;
	localparam int USED_W     = 16;
	localparam int CFG_ADDR_W = 3;

	// register index taken from paddr[2]
	localparam logic REG_BASE   = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	typedef struct packed {
		logic [BASE_W-1:0] base;
		logic [WIN_W-1:0]  window;
	} cfg_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             is_last;
		logic             exhausted;
		logic             config_error;
	} res_t;

endpackage

// File: design/de_bruijn_symbol_generator.sv
// Top level of the De Bruijn symbol generator: register port, output register.
// Depends on dbsg_pkg and dbsg_core.
//
//  channel   direction  handshake                     payload
//  input     in         in_valid / in_stall           restart
//  output    out        out_valid / out_stall         symbol, is_last, exhausted, config_error
//  config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One request at a time; a bad configuration is answered without a walk step.
// Otherwise each edge waits on the remainder unit; a bridge search first clears
// visited marks, then for each dequeued node waits on the remainder unit and
// checks its unused and used edges.
// After reset, a register write or a restart the request also clears the marks of every node.
// in_stall is high while a request is in work; a result holds in the core until drained.
module de_bruijn_symbol_generator import dbsg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  restart,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SYM_W-1:0]      symbol,
	output logic                  is_last,
	output logic                  exhausted,
	output logic                  config_error,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic core_idle;
	logic res_valid;
	logic res_take;
	res_t res;
	res_t out_q;
	logic out_valid_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// register file: base at 0, window at 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base   <= BASE_W'(2);
			cfg_q.window <= WIN_W'(3);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_BASE:   cfg_q.base   <= pwdata[BASE_W-1:0];
				REG_WINDOW: cfg_q.window <= pwdata[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_BASE:   prdata = {{(32-BASE_W){1'b0}}, cfg_q.base};
			REG_WINDOW: prdata = {{(32-WIN_W){1'b0}}, cfg_q.window};
			default:    prdata = '0;
		endcase
	end

	dbsg_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cfg_wr      (cfg_wr),
		.req_valid   (in_valid),
		.req_restart (restart),
		.idle        (core_idle),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res)
	);

	// take a new request only when the sequencer is idle
	assign in_stall = !core_idle;

	// load the output register when it is empty or being drained
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign symbol       = out_q.symbol;
	assign is_last      = out_q.is_last;
	assign exhausted    = out_q.exhausted;
	assign config_error = out_q.config_error;

endmodule

// File: design/dbsg_mod.sv
// Iterative remainder unit: reduces a product modulo the node count.
// Depends on dbsg_pkg.
module dbsg_mod import dbsg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [NCNT_W-1:0] modulus,
	output logic              busy,
	output logic [NODE_W-1:0] remainder
);

	logic [PROD_W-1:0] r_q;
	logic              busy_q;
	logic [PROD_W-1:0] m_ext;

	assign m_ext     = {{(PROD_W-NCNT_W){1'b0}}, modulus};
	assign busy      = busy_q;
	assign remainder = r_q[NODE_W-1:0];

	// subtract one modulus a cycle; the dividend is below modulus * MAX_BASE
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (r_q < m_ext) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= dividend;
		end else if (busy_q && r_q >= m_ext) begin
			r_q <= r_q - m_ext;
		end
	end

endmodule

// File: design/dbsg_core.sv
// Walk sequencer: node-state memory, search queue memory and the Fleury walk.
// Depends on dbsg_pkg and dbsg_mod.
module dbsg_core import dbsg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cfg_wr,
	input  logic req_valid,
	input  logic req_restart,
	output logic idle,
	output logic res_valid,
	input  logic res_take,
	output res_t res
);

	typedef enum logic [23:0] {
		S_IDLE  = 24'h000001, S_NCNT = 24'h000002, S_SETUP = 24'h000004,
		S_CLR   = 24'h000008, S_CHK  = 24'h000010, S_CUR1  = 24'h000020,
		S_CUR2  = 24'h000040, S_TRY  = 24'h000080, S_VRD   = 24'h000100,
		S_VW1   = 24'h000200, S_VW2  = 24'h000400, S_SEED  = 24'h000800,
		S_SD1   = 24'h001000, S_SD2  = 24'h002000, S_QRD   = 24'h004000,
		S_QW1   = 24'h008000, S_QW2  = 24'h010000, S_UW1   = 24'h020000,
		S_UW2   = 24'h040000, S_KS   = 24'h080000, S_KW1   = 24'h100000,
		S_KW2   = 24'h200000, S_TAKE = 24'h400000, S_DONE  = 24'h800000
	} state_t;

	state_t state_q;

	// node memory entry: {visited, used edge marks}
	logic [USED_W:0]   node_mem [MAX_NODES];
	logic [NODE_W-1:0] queue_mem [MAX_NODES];

	logic [USED_W:0]   mem_rdata_q;
	logic [NODE_W-1:0] rd_addr_q;
	logic              mem_we;
	logic [NODE_W-1:0] mem_wa;
	logic [USED_W:0]   mem_wd;

	logic [NODE_W-1:0] q_rdata_q;
	logic [NODE_W-1:0] q_raddr_q;
	logic              q_we;
	logic [NODE_W-1:0] q_wa;
	logic [NODE_W-1:0] q_wd;

	logic              pend_q;
	logic              rst_req_q;
	logic              bad_q;
	logic [NCNT_W-1:0] n_q;
	logic [WIN_W-1:0]  it_q;
	logic [CNT_W-1:0]  edges_q;
	logic [CNT_W-1:0]  count_q;
	logic [NODE_W-1:0] cur_q;
	logic [NODE_W-1:0] addr_q;
	logic [USED_W-1:0] used_c_q;
	logic [NODE_W-1:0] pc_q;
	logic [BASE_W-1:0] e_q;
	logic [NODE_W-1:0] dest_q;
	logic [NCNT_W-1:0] head_q;
	logic [NCNT_W-1:0] tail_q;
	logic [USED_W-1:0] used_u_q;
	logic [NODE_W-1:0] pu_q;
	logic [BASE_W-1:0] k_q;
	logic [NODE_W-1:0] w_q;
	res_t              res_q;

	logic              base_ok;
	logic [15:0]       prod_n;
	logic [USED_W-1:0] base_mask;
	logic              others;
	logic              one_node;
	logic [NODE_W-1:0] pc_plus_e;
	logic [NODE_W-1:0] pu_plus_k;
	logic              cur_exh;
	logic              mod_start;
	logic [PROD_W-1:0] mod_p;
	logic              mod_busy;
	logic [NODE_W-1:0] mod_r;

	dbsg_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_p),
		.modulus   (n_q),
		.busy      (mod_busy),
		.remainder (mod_r)
	);

	assign base_ok   = (cfg.base >= BASE_W'(2)) && (cfg.base <= BASE_W'(MAX_BASE));
	assign prod_n    = {5'b0, n_q} * {11'b0, cfg.base};
	// a one-node graph has only self-loops back to node zero
	assign one_node  = (n_q == NCNT_W'(1));
	assign pc_plus_e = one_node ? '0 : pc_q + {{(NODE_W-SYM_W){1'b0}}, e_q[SYM_W-1:0]};
	assign pu_plus_k = one_node ? '0 : pu_q + {{(NODE_W-SYM_W){1'b0}}, k_q[SYM_W-1:0]};
	assign cur_exh   = (count_q >= edges_q) || ({1'b0, cur_q} >= n_q);

	always_comb begin
		for (int i = 0; i < USED_W; i++) begin
			base_mask[i] = (BASE_W'(i) < cfg.base);
		end
	end

	assign others = |(~used_c_q & base_mask & ~(USED_W'(1) << e_q[SYM_W-1:0]));

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// remainder unit launches: current node at check, dequeued node in search
	always_comb begin
		mod_start = 1'b0;
		mod_p     = {4'b0, cur_q} * {9'b0, cfg.base};
		if (state_q == S_CHK) begin
			mod_start = !cur_exh;
		end else if (state_q == S_QW2) begin
			mod_start = 1'b1;
			mod_p     = {4'b0, q_rdata_q} * {9'b0, cfg.base};
		end
	end

	// memory writes
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = '0;
		q_we   = 1'b0;
		q_wa   = tail_q[NODE_W-1:0];
		q_wd   = w_q;
		unique case (state_q)
			S_CLR: begin
				mem_we = 1'b1;
			end
			S_VW2: begin
				mem_we = 1'b1;
				mem_wd = {1'b0, mem_rdata_q[USED_W-1:0]};
			end
			S_SD2: begin
				mem_we = 1'b1;
				mem_wa = dest_q;
				mem_wd = {1'b1, mem_rdata_q[USED_W-1:0]};
				q_we   = 1'b1;
				q_wa   = '0;
				q_wd   = dest_q;
			end
			S_KW2: begin
				if (!mem_rdata_q[USED_W] && w_q != cur_q && !tail_q[NODE_W]) begin
					mem_we = 1'b1;
					mem_wa = w_q;
					mem_wd = {1'b1, mem_rdata_q[USED_W-1:0]};
					q_we   = 1'b1;
				end
			end
			S_TAKE: begin
				mem_we = 1'b1;
				mem_wa = cur_q;
				mem_wd = {1'b0, used_c_q | (USED_W'(1) << e_q[SYM_W-1:0])};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[mem_wa] <= mem_wd;
		end
		mem_rdata_q <= node_mem[rd_addr_q];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_wa] <= q_wd;
		end
		q_rdata_q <= queue_mem[q_raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pend_q    <= 1'b1;
			rst_req_q <= 1'b0;
			rd_addr_q <= '0;
			q_raddr_q <= '0;
		end else begin
			if (cfg_wr) begin
				pend_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						rst_req_q <= req_restart;
						n_q       <= NCNT_W'(1);
						it_q      <= WIN_W'(1);
						bad_q     <= 1'b0;
						state_q   <= S_NCNT;
					end
				end
				S_NCNT: begin
					if (!base_ok || cfg.window == '0) begin
						bad_q   <= 1'b1;
						state_q <= S_SETUP;
					end else if (it_q >= cfg.window) begin
						state_q <= S_SETUP;
					end else if (prod_n > 16'(MAX_NODES)) begin
						bad_q   <= 1'b1;
						state_q <= S_SETUP;
					end else begin
						n_q  <= prod_n[NCNT_W-1:0];
						it_q <= it_q + WIN_W'(1);
					end
				end
				S_SETUP: begin
					edges_q <= prod_n[CNT_W-1:0];
					addr_q  <= '0;
					if (bad_q) begin
						// flag the configuration only: symbol, is_last, exhausted zero
						res_q   <= {{SYM_W{1'b0}}, 1'b0, 1'b0, 1'b1};
						state_q <= S_DONE;
					end else if (rst_req_q || pend_q) begin
						res_q   <= '0;
						pend_q  <= 1'b0;
						cur_q   <= NODE_W'(n_q - NCNT_W'(1));
						count_q <= '0;
						state_q <= S_CLR;
					end else begin
						res_q   <= '0;
						state_q <= S_CHK;
					end
				end
				S_CLR: begin
					addr_q <= addr_q + NODE_W'(1);
					if ({1'b0, addr_q} == n_q - NCNT_W'(1)) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (cur_exh) begin
						res_q.exhausted <= 1'b1;
						state_q         <= S_DONE;
					end else begin
						rd_addr_q <= cur_q;
						state_q   <= S_CUR1;
					end
				end
				S_CUR1: begin
					state_q <= S_CUR2;
				end
				S_CUR2: begin
					if (!mod_busy) begin
						used_c_q <= mem_rdata_q[USED_W-1:0];
						pc_q     <= mod_r;
						e_q      <= '0;
						state_q  <= S_TRY;
					end
				end
				S_TRY: begin
					dest_q <= pc_plus_e;
					addr_q <= '0;
					if (e_q >= cfg.base) begin
						res_q.exhausted <= 1'b1;
						state_q         <= S_DONE;
					end else if (used_c_q[e_q[SYM_W-1:0]]) begin
						e_q <= e_q + BASE_W'(1);
					end else if (pc_plus_e == cur_q || !others) begin
						state_q <= S_TAKE;
					end else begin
						state_q <= S_VRD;
					end
				end
				// clear visited marks, keep edge marks
				S_VRD: begin
					rd_addr_q <= addr_q;
					state_q   <= S_VW1;
				end
				S_VW1: begin
					state_q <= S_VW2;
				end
				S_VW2: begin
					addr_q <= addr_q + NODE_W'(1);
					if ({1'b0, addr_q} == n_q - NCNT_W'(1)) begin
						state_q <= S_SEED;
					end else begin
						state_q <= S_VRD;
					end
				end
				S_SEED: begin
					rd_addr_q <= dest_q;
					state_q   <= S_SD1;
				end
				S_SD1: begin
					state_q <= S_SD2;
				end
				S_SD2: begin
					head_q  <= '0;
					tail_q  <= NCNT_W'(1);
					state_q <= S_QRD;
				end
				S_QRD: begin
					if (head_q == tail_q) begin
						// destination cannot get back: bridge, try the next edge
						e_q     <= e_q + BASE_W'(1);
						state_q <= S_TRY;
					end else begin
						q_raddr_q <= head_q[NODE_W-1:0];
						state_q   <= S_QW1;
					end
				end
				S_QW1: begin
					state_q <= S_QW2;
				end
				S_QW2: begin
					rd_addr_q <= q_rdata_q;
					state_q   <= S_UW1;
				end
				S_UW1: begin
					state_q <= S_UW2;
				end
				S_UW2: begin
					if (!mod_busy) begin
						used_u_q <= mem_rdata_q[USED_W-1:0];
						pu_q     <= mod_r;
						k_q      <= '0;
						state_q  <= S_KS;
					end
				end
				S_KS: begin
					w_q       <= pu_plus_k;
					rd_addr_q <= pu_plus_k;
					if (k_q >= cfg.base) begin
						head_q  <= head_q + NCNT_W'(1);
						state_q <= S_QRD;
					end else if (used_u_q[k_q[SYM_W-1:0]]) begin
						k_q <= k_q + BASE_W'(1);
					end else begin
						state_q <= S_KW1;
					end
				end
				S_KW1: begin
					state_q <= S_KW2;
				end
				S_KW2: begin
					if (!mem_rdata_q[USED_W] && w_q == cur_q) begin
						state_q <= S_TAKE;
					end else begin
						k_q     <= k_q + BASE_W'(1);
						state_q <= S_KS;
						if (!mem_rdata_q[USED_W] && !tail_q[NODE_W]) begin
							tail_q <= tail_q + NCNT_W'(1);
						end
					end
				end
				S_TAKE: begin
					cur_q         <= pc_plus_e;
					count_q       <= count_q + CNT_W'(1);
					res_q.symbol  <= e_q[SYM_W-1:0];
					res_q.is_last <= (count_q + CNT_W'(1) == edges_q);
					state_q       <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: test/de_bruijn_symbol_generator_tb.sv
// Testbench for de_bruijn_symbol_generator: drives symbol requests and register
// writes, and checks every result against a built-in Euler-walk predictor.
// Depends on dbsg_pkg and the de_bruijn_symbol_generator RTL.
module de_bruijn_symbol_generator_tb;
	import dbsg_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic                  restart;
	logic                  out_valid;
	logic                  out_stall;
	logic [SYM_W-1:0]      symbol;
	logic                  is_last;
	logic                  exhausted;
	logic                  config_error;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	de_bruijn_symbol_generator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall),
		.symbol(symbol), .is_last(is_last), .exhausted(exhausted),
		.config_error(config_error),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Run bookkeeping shared by the stimulus and the result checker.
	res_t symbol_expect[$];
	int   fail_cnt     = 0;
	int   sent_cnt     = 0;
	int   checked_cnt  = 0;
	int   cfg_writes   = 0;
	bit   quiet_mode   = 0;   // no idling on either side while set
	int   hold_request = 0;   // long receiver hold-off, in cycles

	// Predictor state: its own copy of the registers and the walk.
	int unsigned walk_base;
	int unsigned walk_window;
	bit [15:0]   edge_taken[MAX_NODES];
	bit          reached[MAX_NODES];
	int unsigned frontier[MAX_NODES];
	int unsigned walk_node;
	int unsigned walk_count;

	// Node count of the current graph, zero when the settings cannot be served.
	function automatic int unsigned graph_size();
		longint unsigned n = 1;
		if (walk_base < 2 || walk_base > MAX_BASE || walk_window < 1)
			return 0;
		for (int i = 1; i < walk_window; i++) begin
			n = n * walk_base;
			if (n > MAX_NODES)
				return 0;
		end
		return int'(n);
	endfunction

	function automatic int unsigned succ_node(int unsigned v, int unsigned e,
			int unsigned nodes);
		return (v * walk_base + e) % nodes;
	endfunction

	function automatic void restart_walk();
		int unsigned nodes;
		nodes = graph_size();
		foreach (edge_taken[i])
			edge_taken[i] = '0;
		walk_node  = (nodes != 0) ? nodes - 1 : 0;
		walk_count = 0;
	endfunction

	// Fleury's rule: an edge is a bridge when the unused edges reachable
	// from its far end no longer lead back to the current node.
	function automatic bit edge_cuts_walk(int unsigned v, int unsigned e, int unsigned nodes);
		int unsigned dest;
		int unsigned head;
		int unsigned tail;
		int unsigned u;
		int unsigned w;
		bit          other;
		dest  = succ_node(v, e, nodes);
		other = 0;
		if (dest == v)
			return 0;
		for (int k = 0; k < walk_base; k++)
			if (k != e && !edge_taken[v][k])
				other = 1;
		if (!other)
			return 0;
		foreach (reached[i])
			reached[i] = 0;
		frontier[0]   = dest;
		reached[dest] = 1;
		head = 0;
		tail = 1;
		while (head != tail && head < MAX_NODES) begin
			u = frontier[head];
			for (int k = 0; k < walk_base; k++) begin
				if (edge_taken[u][k])
					continue;
				w = succ_node(u, k, nodes);
				if (reached[w])
					continue;
				if (w == v)
					return 0;
				if (tail < MAX_NODES) begin
					frontier[tail] = w;
					reached[w]     = 1;
					tail++;
				end
			end
			head++;
		end
		return 1;
	endfunction

	function automatic res_t predict_symbol(bit rs);
		res_t        r;
		int unsigned nodes;
		int unsigned edges;
		r     = '0;
		nodes = graph_size();
		if (nodes == 0) begin
			r.config_error = 1;
			return r;
		end
		if (rs)
			restart_walk();
		edges = nodes * walk_base;
		if (walk_count >= edges || walk_node >= nodes) begin
			r.exhausted = 1;
			return r;
		end
		for (int e = 0; e < walk_base; e++) begin
			if (!edge_taken[walk_node][e] && !edge_cuts_walk(walk_node, e, nodes)) begin
				edge_taken[walk_node][e] = 1;
				walk_node  = succ_node(walk_node, e, nodes);
				walk_count++;
				r.symbol  = e[SYM_W-1:0];
				r.is_last = (walk_count == edges);
				return r;
			end
		end
		r.exhausted = 1;
		return r;
	endfunction

	// Clock and the run limit.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#200_000_000;
		$display("%0t: timeout with %0d results outstanding", $time, symbol_expect.size());
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_request > 0) begin
			out_stall    <= 1'b1;
			hold_request <= hold_request - 1;
		end else begin
			out_stall <= !quiet_mode && ($urandom_range(99) < 10);
		end
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (symbol_expect.size() == 0) begin
				$display("%0t: unexpected result sym=%0d last=%0d exh=%0d err=%0d",
					$time, symbol, is_last, exhausted, config_error);
				fail_cnt++;
			end else begin
				want = symbol_expect.pop_front();
				checked_cnt++;
				if (symbol !== want.symbol) begin
					$display("%0t: symbol expected %0d got %0d", $time, want.symbol, symbol);
					fail_cnt++;
				end
				if (is_last !== want.is_last) begin
					$display("%0t: is_last expected %0d got %0d", $time, want.is_last, is_last);
					fail_cnt++;
				end
				if (exhausted !== want.exhausted) begin
					$display("%0t: exhausted expected %0d got %0d", $time,
						want.exhausted, exhausted);
					fail_cnt++;
				end
				if (config_error !== want.config_error) begin
					$display("%0t: config_error expected %0d got %0d", $time,
						want.config_error, config_error);
					fail_cnt++;
				end
			end
		end
	end

	// Offer one request and hold it until accepted; valid stays high after unless a random gap is taken.
	task automatic send_request(bit rs);
		in_valid <= 1'b1;
		restart  <= rs;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		symbol_expect.push_back(predict_symbol(rs));
		sent_cnt++;
		// drop valid for a random gap now and then
		if (!quiet_mode && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			restart  <= 1'($urandom_range(1));
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Drain all results, then write one register over the APB port.
	task automatic write_reg(logic idx, logic [31:0] value);
		in_valid <= 1'b0;
		wait (symbol_expect.size() == 0);
		repeat (4) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_BASE)
			walk_base = 32'(value[BASE_W-1:0]);
		else
			walk_window = 32'(value[WIN_W-1:0]);
		restart_walk();
		cfg_writes++;
	endtask

	task automatic set_graph(int unsigned b, int unsigned w);
		write_reg(REG_BASE, {27'($urandom_range(2047)), b[BASE_W-1:0]});
		write_reg(REG_WINDOW, {28'($urandom_range(4095)), w[WIN_W-1:0]});
	endtask

	// Reset settings: the full sequence, one beyond its end, then a restart.
	task automatic test_reset_sequence();
		for (int i = 0; i < 9; i++)
			send_request(1'b0);
		send_request(1'b1);
		send_request(1'b0);
	endtask

	// Settings at the extremes, valid and invalid.
	task automatic test_config_extremes();
		set_graph(2, 1);    // one node, self-loops only
		repeat (3) send_request(1'b0);
		set_graph(16, 1);
		send_request(1'b0);
		send_request(1'b1);
		set_graph(16, 3);   // 256 nodes, widest alphabet
		repeat (2) send_request(1'b0);
		set_graph(2, 11);   // 1024 nodes, deepest searches
		repeat (2) send_request(1'b0);
		set_graph(16, 4);   // beyond node capacity
		send_request(1'b0);
		set_graph(1, 3);
		send_request(1'b1);
		set_graph(31, 15);
		send_request(1'b0);
		set_graph(17, 2);
		send_request(1'b0);
		set_graph(3, 0);
		send_request(1'b1);
	endtask

	// Random small graphs, mostly walked to the end with occasional restarts.
	task automatic test_random_walks();
		int unsigned b;
		int unsigned w;
		int unsigned len;
		for (int p = 0; p < 5; p++) begin
			if ($urandom_range(9) == 0) begin
				set_graph($urandom_range(31), $urandom_range(15));
				repeat (2) send_request(1'($urandom_range(1)));
				continue;
			end
			b = $urandom_range(2, 4);
			w = (b == 2) ? $urandom_range(1, 4) : $urandom_range(1, 3);
			set_graph(b, w);
			len = graph_size() * b;
			for (int i = 0; i < len + 1; i++)
				send_request($urandom_range(29) == 0);
		end
	endtask

	// Hold the receiver off while requests pile up, then pause until drained.
	task automatic test_backpressure();
		set_graph(3, 2);
		quiet_mode = 1;
		hold_request = 300;
		for (int i = 0; i < 6; i++)
			send_request(1'b0);
		in_valid <= 1'b0;
		wait (symbol_expect.size() == 0);
		for (int i = 0; i < 6; i++)
			send_request(i == 0);
		quiet_mode = 0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		restart   = 1'b0;
		out_stall = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		walk_base   = 2;
		walk_window = 3;
		restart_walk();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sequence();
		test_config_extremes();
		test_backpressure();
		test_random_walks();

		in_valid <= 1'b0;
		wait (symbol_expect.size() == 0);
		repeat (50) @(posedge clk);
		$display("Covered %0d requests and %0d register writes; %0d results checked.",
			sent_cnt, cfg_writes, checked_cnt);
		$display("Walks over small and full-size graphs, bad settings, restarts, stalls.");
		if (fail_cnt == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
